// ===== hdl/swcd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the stable weight change detector.
// No dependencies; every other source file except swcd_ram imports this package.
package swcd_pkg;

   // Window capacity and sample width
   localparam int MAX_WINDOW  = 8;
   localparam int SAMPLE_BITS = 32;

   // Derived widths
   localparam int ADDR_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int RAM_DEPTH   = 2 ** ADDR_BITS;
   localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
   localparam int CHANGE_BITS = SAMPLE_BITS + 1;
   localparam int INDEX_BITS  = 32;

   // Register file
   localparam int SENS_BITS      = 31;
   localparam int WSIZE_BITS     = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [SENS_BITS-1:0]  SENS_RESET  = SENS_BITS'(9830);  // 0.15 in Q15.16
   localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(4);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SENSITIVITY = 2'd0,
      REG_WINDOW_SIZE = 2'd1
   } csr_reg_type;

   // Commands to the sorted row
   typedef struct packed {
      logic                          clear;   // empty the row
      logic                          insert;  // insert data in order
      logic                          calc;    // register the median
      logic signed [SAMPLE_BITS-1:0] data;
   } sort_cmd_type;

endpackage

// ===== hdl/swcd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample input, result output, register writes.
// Depends on swcd_pkg for field widths.

interface swcd_req_if import swcd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] weight_sample;

   modport source (output valid, output weight_sample, input ready);
   modport sink   (input valid, input weight_sample, output ready);
endinterface

interface swcd_rsp_if import swcd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic                          changed;
   logic signed [SAMPLE_BITS-1:0] stable_weight;
   logic signed [CHANGE_BITS-1:0] last_change;
   logic [INDEX_BITS-1:0]         change_index;

   modport source (output valid, output changed, output stable_weight,
                   output last_change, output change_index, input ready);
   modport sink   (input valid, input changed, input stable_weight,
                   input last_change, input change_index, output ready);
endinterface

interface swcd_csr_if import swcd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/swcd_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one registered read port.
// Generic; no package dependency.
module swcd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/swcd_sort.sv =====
`timescale 1ns / 1ps
// Sorted row of window samples built by insertion, plus median selection.
// Depends on swcd_pkg.
module swcd_sort import swcd_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  sort_cmd_type                  cmd,
   output logic signed [SAMPLE_BITS-1:0] median
);

   logic signed [SAMPLE_BITS-1:0] row_ff [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] row_in [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] prev   [MAX_WINDOW];
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in, cnt_base;
   logic [MAX_WINDOW-1:0]         below, greater, shift;
   logic signed [SAMPLE_BITS-1:0] median_ff, median_in;
   logic signed [SAMPLE_BITS-1:0] mid_hi, mid_lo;
   logic signed [CHANGE_BITS-1:0] mid_sum;
   logic [CNT_BITS-1:0]           mid;

   // Insertion: entries above the new value move up one place
   always_comb begin
      cnt_base = cmd.clear ? '0 : cnt_ff;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         below[i]   = CNT_BITS'(i) < cnt_base;
         greater[i] = row_ff[i] > cmd.data;
      end
      shift[0] = 1'b0;
      prev[0]  = cmd.data;
      for (int i = 1; i < MAX_WINDOW; i++) begin
         shift[i] = below[i-1] && greater[i-1];
         prev[i]  = row_ff[i-1];
      end
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (below[i] && !greater[i]) begin
            row_in[i] = row_ff[i];
         end else if (shift[i]) begin
            row_in[i] = prev[i];
         end else begin
            row_in[i] = cmd.data;
         end
      end
      cnt_in = cmd.insert ? cnt_base + 1'b1 : cnt_base;
   end

   // Median: middle entry, or floored mean of the two middle entries
   always_comb begin
      mid    = cnt_ff >> 1;
      mid_hi = '0;
      mid_lo = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (CNT_BITS'(i) == mid) begin
            mid_hi = row_ff[i];
         end
         if (CNT_BITS'(i + 1) == mid) begin
            mid_lo = row_ff[i];
         end
      end
      mid_sum   = CHANGE_BITS'(mid_hi) + CHANGE_BITS'(mid_lo);
      median_in = cnt_ff[0] ? mid_hi : mid_sum[CHANGE_BITS-1:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         for (int i = 0; i < MAX_WINDOW; i++) begin
            row_ff[i] <= row_in[i];
         end
      end
      if (cmd.calc) begin
         median_ff <= median_in;
      end
   end

   assign median = median_ff;

endmodule

// ===== hdl/stable_weight_change_detector.sv =====
`timescale 1ns / 1ps
// Stable weight change detector. Each accepted sample is checked against the
// window of recent samples, which lives in a small RAM read one entry per
// cycle. From one accepted sample to the next an item goes through these steps
// in order: one scan read per held sample, a drain of the last RAM read when
// samples are held, the write-back of the sample, the median, the decision
// (which waits for a free result slot) and idle to take the next sample.
// The next sample is taken while a result still waits on the output
// register.
// Writing window_size empties the window. Depends on swcd_pkg, swcd_if,
// swcd_ram and swcd_sort.
module stable_weight_change_detector import swcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   swcd_req_if.sink   req_chan,
   swcd_rsp_if.source rsp_chan,
   swcd_csr_if.sink   csr_chan
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_MEDIAN = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [SENS_BITS-1:0]          sens_ff, sens_in;
   logic [WSIZE_BITS-1:0]         wsize_ff, wsize_in;
   logic [CNT_BITS-1:0]           fill_ff, fill_in;
   logic [ADDR_BITS-1:0]          head_ff, head_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                          stable_ff, stable_in;
   logic [CNT_BITS-1:0]           rk_ff, rk_in;
   logic [CNT_BITS-1:0]           pk_ff, pk_in;
   logic                          vld_ff, vld_in;
   logic signed [SAMPLE_BITS-1:0] held_stable_ff, held_stable_in;
   logic signed [CHANGE_BITS-1:0] held_change_ff, held_change_in;
   logic [INDEX_BITS-1:0]         count_ff, count_in;
   logic [INDEX_BITS-1:0]         held_index_ff, held_index_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          changed_ff, changed_in;

   logic                          req_xfer, csr_xfer, slot_free, rd_en, scan_done;
   logic [CNT_BITS-1:0]           cap, keep;
   logic [ADDR_BITS-1:0]          rd_addr;
   logic signed [SAMPLE_BITS-1:0] rd_data, median;
   logic signed [CHANGE_BITS-1:0] scan_diff, med_diff;
   logic [CHANGE_BITS-1:0]        scan_mag, med_mag;
   logic                          is_change;
   sort_cmd_type                  sort_cmd;

   // Handshakes
   assign req_xfer          = req_chan.valid && req_chan.ready;
   assign csr_xfer          = csr_chan.valid && csr_chan.ready;
   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign csr_chan.ready    = 1'b1;
   assign slot_free         = !rsp_valid_ff || rsp_chan.ready;

   // Effective capacity and number of old samples that stay after the push
   always_comb begin
      if (wsize_ff == '0) begin
         cap = CNT_BITS'(1);
      end else if (int'(wsize_ff) > MAX_WINDOW) begin
         cap = CNT_BITS'(MAX_WINDOW);
      end else begin
         cap = CNT_BITS'(wsize_ff);
      end
      keep = (fill_ff >= cap) ? cap - 1'b1 : fill_ff;
   end

   // Window scan: newest entry first, one RAM read per cycle
   assign rd_en     = (state_ff == ST_SCAN) && (rk_ff < fill_ff);
   assign rd_addr   = head_ff - ADDR_BITS'(1) - rk_ff[ADDR_BITS-1:0];
   assign scan_done = (state_ff == ST_SCAN) && !rd_en && !vld_ff;
   assign scan_diff = CHANGE_BITS'(sample_ff) - CHANGE_BITS'(rd_data);
   assign scan_mag  = scan_diff[CHANGE_BITS-1] ? CHANGE_BITS'(-scan_diff)
                                               : CHANGE_BITS'(scan_diff);

   swcd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RAM_DEPTH),
      .AW    (ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (scan_done),
      .wr_addr (head_ff),
      .wr_data (sample_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sorted copy of the new window
   always_comb begin
      sort_cmd.clear  = req_xfer;
      sort_cmd.insert = req_xfer || ((state_ff == ST_SCAN) && vld_ff && (pk_ff < keep));
      sort_cmd.calc   = (state_ff == ST_MEDIAN);
      sort_cmd.data   = req_xfer ? req_chan.weight_sample : rd_data;
   end

   swcd_sort u_sort (
      .clock  (clock),
      .reset  (reset),
      .cmd    (sort_cmd),
      .median (median)
   );

   // Change decision against the held stable weight
   assign med_diff  = CHANGE_BITS'(median) - CHANGE_BITS'(held_stable_ff);
   assign med_mag   = med_diff[CHANGE_BITS-1] ? CHANGE_BITS'(-med_diff)
                                              : CHANGE_BITS'(med_diff);
   assign is_change = stable_ff && (med_mag > CHANGE_BITS'(sens_ff));

   // Sequencer and state update
   always_comb begin
      state_in       = state_ff;
      sens_in        = sens_ff;
      wsize_in       = wsize_ff;
      fill_in        = fill_ff;
      head_in        = head_ff;
      sample_in      = sample_ff;
      stable_in      = stable_ff;
      rk_in          = rk_ff;
      pk_in          = rk_ff;
      vld_in         = rd_en;
      held_stable_in = held_stable_ff;
      held_change_in = held_change_ff;
      count_in       = count_ff;
      held_index_in  = held_index_ff;
      changed_in     = changed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      if (csr_xfer) begin
         unique case (csr_chan.index)
            REG_SENSITIVITY: sens_in = csr_chan.data[SENS_BITS-1:0];
            REG_WINDOW_SIZE: begin
               wsize_in = csr_chan.data[WSIZE_BITS-1:0];
               fill_in  = '0;
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sample_in = req_chan.weight_sample;
               stable_in = 1'b1;
               rk_in     = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               rk_in = rk_ff + 1'b1;
            end
            if (vld_ff && (scan_mag >= CHANGE_BITS'(sens_ff))) begin
               stable_in = 1'b0;
            end
            if (scan_done) begin
               fill_in  = keep + 1'b1;
               head_in  = head_ff + 1'b1;
               state_in = ST_MEDIAN;
            end
         end
         ST_MEDIAN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (slot_free) begin
               if (is_change) begin
                  held_stable_in = median;
                  held_change_in = med_diff;
                  held_index_in  = count_ff;
               end
               changed_in   = is_change;
               count_in     = count_ff + 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         sens_ff        <= SENS_RESET;
         wsize_ff       <= WSIZE_RESET;
         fill_ff        <= '0;
         head_ff        <= '0;
         rk_ff          <= '0;
         vld_ff         <= 1'b0;
         held_stable_ff <= '0;
         held_change_ff <= '0;
         count_ff       <= '0;
         held_index_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sens_ff        <= sens_in;
         wsize_ff       <= wsize_in;
         fill_ff        <= fill_in;
         head_ff        <= head_in;
         rk_ff          <= rk_in;
         vld_ff         <= vld_in;
         held_stable_ff <= held_stable_in;
         held_change_ff <= held_change_in;
         count_ff       <= count_in;
         held_index_ff  <= held_index_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      stable_ff  <= stable_in;
      pk_ff      <= pk_in;
      changed_ff <= changed_in;
   end

   // Result register; held values change only when a result is loaded
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.changed       = changed_ff;
   assign rsp_chan.stable_weight = held_stable_ff;
   assign rsp_chan.last_change   = held_change_ff;
   assign rsp_chan.change_index  = held_index_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_BITS'(MAX_WINDOW))
      else $error("window fill exceeds capacity");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_SCAN) && (rk_ff == '0) && stable_ff)
      else $error("accepted sample did not start a scan");

   a_result_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DECIDE)
      else $error("result raised outside the decision step");

   a_change_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && changed_ff) |-> (held_change_ff != '0))
      else $error("change flagged with zero change");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stable_weight_change_detector: drives samples, random
// register settings and handshake stalls, and checks every result against a
// built-in predictor. Depends on swcd_pkg, swcd_if and the detector RTL.
module testbench;
   import swcd_pkg::*;

   localparam int  CYCLE_LIMIT   = 1000000;
   localparam int  PHASE_ITEMS   = 178;
   localparam int  HOLD_CYCLES   = 400;
   localparam int  DRAIN_CYCLES  = 30;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;
   localparam longint SAMPLE_MAX = 64'sd2147483647;
   localparam longint SAMPLE_MIN = -64'sd2147483648;

   typedef struct {
      bit                            changed;
      logic signed [SAMPLE_BITS-1:0] stable_weight;
      logic signed [CHANGE_BITS-1:0] last_change;
      logic [INDEX_BITS-1:0]         change_index;
   } weight_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   swcd_req_if req_chan ();
   swcd_rsp_if rsp_chan ();
   swcd_csr_if csr_chan ();

   stable_weight_change_detector u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predictor state: shadow of the detector's registers and window
   longint                cfg_sens;
   logic [WSIZE_BITS-1:0] cfg_wsize;
   longint                win_samples [MAX_WINDOW];
   int                    win_fill;
   longint                cur_stable;
   longint                cur_change;
   logic [INDEX_BITS-1:0] cur_change_idx;
   logic [INDEX_BITS-1:0] sample_count;

   logic [SAMPLE_BITS-1:0] pending_samples [$];
   weight_result_type      expected_results [$];
   int                     accepted_count = 0;
   int                     err_count = 0;
   int                     cycle_count = 0;
   int                     send_gap = 0;
   int                     recv_stall = 0;
   bit                     burst_mode = 1'b0;
   bit                     hold_off = 1'b0;
   longint                 gen_level = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint clamp_sample(longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   function automatic longint abs_val(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Random value in [-r, r], with r capped at 1073741823
   function automatic longint spread(longint r);
      longint lim;
      lim = (r > 64'sd1073741823) ? 64'sd1073741823 : r;
      if (lim <= 0) return 0;
      return longint'($urandom_range(0, 32'(2 * lim))) - lim;
   endfunction

   // Gap length: mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic reset_predictor();
      cfg_sens       = longint'(SENS_RESET);
      cfg_wsize      = WSIZE_RESET;
      win_fill       = 0;
      cur_stable     = 0;
      cur_change     = 0;
      cur_change_idx = '0;
      sample_count   = '0;
      foreach (win_samples[i]) win_samples[i] = 0;
   endtask

   task automatic apply_config(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         REG_SENSITIVITY: cfg_sens = longint'(value[SENS_BITS-1:0]);
         REG_WINDOW_SIZE: begin
            cfg_wsize = value[WSIZE_BITS-1:0];
            win_fill  = 0;
         end
         default: ;
      endcase
   endtask

   // Stability check against the window, push, then median and change decision
   function automatic weight_result_type weigh_sample(logic signed [SAMPLE_BITS-1:0] smp);
      weight_result_type res;
      longint         s;
      longint         med;
      longint         diff;
      longint         key;
      longint         sorted [MAX_WINDOW];
      int             cap;
      int             j;
      bit             stable;
      s      = longint'(smp);
      stable = 1'b1;
      res.changed = 1'b0;
      for (int i = 0; i < win_fill; i++)
         if (!(abs_val(s - win_samples[i]) < cfg_sens)) stable = 1'b0;
      cap = (cfg_wsize == 0) ? 1 : (cfg_wsize > MAX_WINDOW) ? MAX_WINDOW : int'(cfg_wsize);
      if (win_fill > cap) win_fill = cap;
      if (win_fill == cap) win_fill--;
      for (int i = win_fill; i > 0; i--) win_samples[i] = win_samples[i-1];
      win_samples[0] = s;
      win_fill++;
      if (stable) begin
         // insertion sort on a copy so the window keeps arrival order
         for (int i = 0; i < win_fill; i++) sorted[i] = win_samples[i];
         for (int i = 1; i < win_fill; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = key;
         end
         if (win_fill % 2 == 1) med = sorted[win_fill / 2];
         else med = (sorted[win_fill/2 - 1] + sorted[win_fill/2]) >>> 1;
         diff = med - cur_stable;
         if (abs_val(diff) > cfg_sens) begin
            cur_change     = diff;
            cur_stable     = med;
            cur_change_idx = sample_count;
            res.changed    = 1'b1;
         end
      end
      sample_count++;
      res.stable_weight = cur_stable[SAMPLE_BITS-1:0];
      res.last_change   = cur_change[CHANGE_BITS-1:0];
      res.change_index  = cur_change_idx;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      if (err_count < 40)
         $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want,
                  accepted_count);
      err_count++;
   endtask

   // Sample driver: one transfer per handshake, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.weight_sample <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(weigh_sample(req_chan.weight_sample));
            accepted_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_chan.valid <= 1'b1;
               req_chan.weight_sample <= pending_samples.pop_front();
               send_gap = pick_gap();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      weight_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.changed !== want.changed)
                  report_mismatch("changed", rsp_chan.changed, want.changed);
               if (rsp_chan.stable_weight !== want.stable_weight)
                  report_mismatch("stable_weight", rsp_chan.stable_weight, want.stable_weight);
               if (rsp_chan.last_change !== want.last_change)
                  report_mismatch("last_change", rsp_chan.last_change, want.last_change);
               if (rsp_chan.change_index !== want.change_index)
                  report_mismatch("change_index", rsp_chan.change_index, want.change_index);
            end
         end
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            recv_stall = ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
         end
      end
   end

   // Long receiver hold-off while the sender keeps offering samples
   initial begin
      do @(negedge clock); while (accepted_count < 600 || pending_samples.size() < 40);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      apply_config(idx, value);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_chan.valid || expected_results.size() != 0);
   endtask

   // Mostly stable runs around a level that jumps now and then, plus raw noise
   function automatic logic [SAMPLE_BITS-1:0] next_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) return $urandom();
      if (r < 18) begin
         if (cfg_sens < 64'sd67108864 && $urandom_range(0, 3) != 0)
            gen_level = clamp_sample(gen_level + spread(4 * cfg_sens + 65536));
         else
            gen_level = longint'($signed($urandom())) >>> $urandom_range(0, 20);
      end
      return SAMPLE_BITS'(clamp_sample(gen_level + spread(cfg_sens / 3)));
   endfunction

   // Stimulus
   initial begin
      longint                sens;
      logic [WSIZE_BITS-1:0] wsize;
      req_chan.valid         = 1'b0;
      req_chan.weight_sample = '0;
      rsp_chan.ready         = 1'b0;
      csr_chan.valid         = 1'b0;
      csr_chan.index         = REG_SENSITIVITY;
      csr_chan.data          = '0;
      reset_predictor();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty window, field extremes, stable runs, floored even median
      pending_samples.push_back(32'sd0);
      pending_samples.push_back(32'h7FFF_FFFF);
      pending_samples.push_back(32'h8000_0000);
      pending_samples.push_back(32'hFFFF_FFFF);
      pending_samples.push_back(32'sd65536);
      pending_samples.push_back(32'sd65636);
      pending_samples.push_back(32'sd65336);
      pending_samples.push_back(32'sd65586);
      pending_samples.push_back(32'sd65536);
      pending_samples.push_back(-32'sd65537);
      pending_samples.push_back(-32'sd65536);
      pending_samples.push_back(-32'sd65537);
      pending_samples.push_back(-32'sd65536);
      repeat (4) pending_samples.push_back(32'h7FFF_FFF0);
      repeat (4) pending_samples.push_back(32'h8000_0010);
      wait_idle();

      // Register settings, extremes first, each followed by random samples
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin sens = 0;                                 wsize = 4'd1;  end
            1: begin sens = longint'(31'h7FFF_FFFF);           wsize = 4'd8;  end
            2: begin sens = 9830;                              wsize = 4'd0;  end
            3: begin sens = 65536;                             wsize = 4'd15; end
            4: begin sens = $urandom_range(1, 1 << 18);        wsize = 4'd2;  end
            5: begin sens = $urandom_range(1 << 10, 1 << 20);  wsize = 4'd3;  end
            6: begin sens = $urandom_range(1 << 12, 1 << 24);  wsize = 4'd9;  end
            7: begin sens = $urandom_range(1 << 8, 1 << 16);   wsize = 4'd5;  end
            8: begin sens = 1;                                 wsize = 4'd6;  end
            default: begin sens = $urandom_range(0, 32'h7FFF_FFFF); wsize = 4'd7; end
         endcase
         if ($urandom_range(0, 1) == 0) begin
            csr_write(REG_SENSITIVITY, {1'($urandom_range(0, 1)), SENS_BITS'(sens)});
            csr_write(REG_WINDOW_SIZE, {28'($urandom()), wsize});
         end else begin
            csr_write(REG_WINDOW_SIZE, {28'($urandom()), wsize});
            csr_write(REG_SENSITIVITY, {1'($urandom_range(0, 1)), SENS_BITS'(sens)});
         end
         // writes to unused indexes must change nothing
         if (ph == 2 || ph == 5) begin
            csr_write(REG_SPARE_A, $urandom());
            csr_write(REG_SPARE_B, $urandom());
         end
         burst_mode = ($urandom_range(0, 3) == 0);
         gen_level  = longint'($signed($urandom())) >>> $urandom_range(0, 16);
         for (int n = 0; n < PHASE_ITEMS; n++) pending_samples.push_back(next_sample());
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results missing", 0, expected_results.size());
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/swcd_pkg.sv
hdl/swcd_if.sv
hdl/swcd_ram.sv
hdl/swcd_sort.sv
hdl/stable_weight_change_detector.sv
bench/testbench.sv
